### rtl/mdtw_pkg.sv
// mdtw_pkg: shared types and constants for the duplicate suppression table
// payload structs, scan packet and write-back bus used by cells, result stage and top
`default_nettype none

package mdtw_pkg;

  localparam int unsigned DefEntries  = 32;
  localparam int unsigned AddrW       = 48;
  localparam int unsigned TimeW       = 32;
  localparam logic [TimeW-1:0] WindowReset = 32'd5000;

  typedef struct packed {
    logic [AddrW-1:0] station_addr;
    logic [TimeW-1:0] time_ms;
  } in_t;

  typedef struct packed {
    logic suppress;
    logic new_entry;
  } out_t;

  // query walking down the cell row, indexes travel beside it
  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] addr;
    logic [TimeW-1:0] now;
    logic             found;
    logic [TimeW-1:0] match_time;
    logic [TimeW-1:0] min_time;
  } scan_pkt_t;

  typedef struct packed {
    logic             en;
    logic             set_addr;
    logic [AddrW-1:0] addr;
    logic [TimeW-1:0] stamp;
  } wr_t;

endpackage

`default_nettype wire

### rtl/mdtw_cell.sv
// mdtw_cell: one table entry plus one stage of the scan packet
// depends on mdtw_pkg
`default_nettype none

module mdtw_cell #(
  parameter int unsigned IdxW = 5,
  parameter int unsigned IDX  = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mdtw_pkg::scan_pkt_t  pkt_i,
  input  logic [IdxW-1:0]      match_idx_i,
  input  logic [IdxW-1:0]      min_idx_i,
  output mdtw_pkg::scan_pkt_t  pkt_o,
  output logic [IdxW-1:0]      match_idx_o,
  output logic [IdxW-1:0]      min_idx_o,
  input  mdtw_pkg::wr_t        wr_i,
  input  logic [IdxW-1:0]      wr_idx_i
);
  import mdtw_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(IDX);

  logic [AddrW-1:0] addr_q;
  logic [TimeW-1:0] time_q;
  scan_pkt_t        pkt_d, pkt_q;
  logic [IdxW-1:0]  match_idx_d, match_idx_q, min_idx_d, min_idx_q;
  logic             hit, older;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      time_q <= '0;
    end else if (wr_i.en && (wr_idx_i == MyIdx)) begin
      time_q <= wr_i.stamp;
      if (wr_i.set_addr) begin
        addr_q <= wr_i.addr;
      end
    end
  end

  assign hit   = pkt_i.valid && !pkt_i.found && (pkt_i.addr == addr_q);
  // strict compare keeps the lowest index on ties
  assign older = time_q < pkt_i.min_time;

  always_comb begin
    pkt_d       = pkt_i;
    match_idx_d = match_idx_i;
    min_idx_d   = min_idx_i;
    if (hit) begin
      pkt_d.found      = 1'b1;
      pkt_d.match_time = time_q;
      match_idx_d      = MyIdx;
    end
    if (older) begin
      pkt_d.min_time = time_q;
      min_idx_d      = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q <= '0;
    end else begin
      pkt_q <= pkt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_idx_q <= match_idx_d;
    min_idx_q   <= min_idx_d;
  end

  assign pkt_o       = pkt_q;
  assign match_idx_o = match_idx_q;
  assign min_idx_o   = min_idx_q;

endmodule

`default_nettype wire

### rtl/mdtw_out.sv
// mdtw_out: evaluates the packet leaving the last cell, drives write-back
// and holds the result in an output register with one spare slot; depends on mdtw_pkg
`default_nettype none

module mdtw_out #(
  parameter int unsigned IdxW = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mdtw_pkg::scan_pkt_t  pkt_i,
  input  logic [IdxW-1:0]      match_idx_i,
  input  logic [IdxW-1:0]      min_idx_i,
  input  logic [31:0]          window_i,
  output mdtw_pkg::wr_t        wr_o,
  output logic [IdxW-1:0]      wr_idx_o,
  output logic                 done_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mdtw_pkg::out_t       out_data_o
);
  import mdtw_pkg::*;

  logic [TimeW-1:0] age;
  logic             in_win;
  out_t             res;
  out_t             hold_d, hold_q, out_d, out_q, cand;
  logic             hold_valid_d, hold_valid_q, out_valid_d, out_valid_q;
  logic             cand_valid, out_free;

  // wrapping difference
  assign age    = pkt_i.now - pkt_i.match_time;
  assign in_win = age < window_i;

  always_comb begin
    res.suppress  = pkt_i.found && in_win;
    res.new_entry = !pkt_i.found;
    wr_o.en       = pkt_i.valid && !(pkt_i.found && in_win);
    wr_o.set_addr = !pkt_i.found;
    wr_o.addr     = pkt_i.addr;
    wr_o.stamp    = pkt_i.now;
    wr_idx_o      = pkt_i.found ? match_idx_i : min_idx_i;
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign cand_valid = pkt_i.valid || hold_valid_q;
  assign cand       = hold_valid_q ? hold_q : res;

  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    if (out_free) begin
      hold_valid_d = 1'b0;
      if (cand_valid) begin
        out_valid_d = 1'b1;
        out_d       = cand;
      end
    end else if (pkt_i.valid) begin
      hold_valid_d = 1'b1;
      hold_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    hold_q <= hold_d;
  end

  assign done_o      = cand_valid && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/mac_dedup_time_window.sv
// mac_dedup_time_window: address table with time-window duplicate suppression
// an input transfer is registered at the head, walks the ENTRIES cells and lands in the output register
// one item at a time: no new input is taken until the query has walked the cell row
// and its result has moved into the output register
// reset: all entries cleared to zero at once, window back to 5000, no clearing pass
// depends on mdtw_pkg, mdtw_cell, mdtw_out
`default_nettype none

module mac_dedup_time_window #(
  parameter int unsigned ENTRIES = mdtw_pkg::DefEntries
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mdtw_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mdtw_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [31:0]    cfg_data_i
);
  import mdtw_pkg::*;

  localparam int unsigned IdxW = $clog2(ENTRIES);

  logic             busy_q, busy_d;
  logic [TimeW-1:0] window_q;
  scan_pkt_t        head_d, head_q;
  scan_pkt_t        chain_pkt [ENTRIES+1];
  logic [IdxW-1:0]  chain_mi [ENTRIES+1];
  logic [IdxW-1:0]  chain_ni [ENTRIES+1];
  wr_t              wr;
  logic [IdxW-1:0]  wr_idx;
  logic             done, in_xfer;

  assign in_ready_o  = !busy_q;
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && in_ready_o;

  always_comb begin
    head_d            = '0;
    head_d.valid      = in_xfer;
    head_d.addr       = in_data_i.station_addr;
    head_d.now        = in_data_i.time_ms;
    head_d.found      = 1'b0;
    head_d.match_time = '0;
    head_d.min_time   = '1;
  end

  always_comb begin
    busy_d = busy_q;
    if (in_xfer) begin
      busy_d = 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      head_q   <= '0;
      window_q <= WindowReset;
    end else begin
      busy_q <= busy_d;
      head_q <= head_d;
      if (cfg_valid_i && cfg_ready_o) begin
        window_q <= cfg_data_i;
      end
    end
  end

  assign chain_pkt[0] = head_q;
  assign chain_mi[0]  = '0;
  assign chain_ni[0]  = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    mdtw_cell #(
      .IdxW (IdxW),
      .IDX  (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .pkt_i       (chain_pkt[g]),
      .match_idx_i (chain_mi[g]),
      .min_idx_i   (chain_ni[g]),
      .pkt_o       (chain_pkt[g+1]),
      .match_idx_o (chain_mi[g+1]),
      .min_idx_o   (chain_ni[g+1]),
      .wr_i        (wr),
      .wr_idx_i    (wr_idx)
    );
  end

  mdtw_out #(
    .IdxW (IdxW)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_i       (chain_pkt[ENTRIES]),
    .match_idx_i (chain_mi[ENTRIES]),
    .min_idx_i   (chain_ni[ENTRIES]),
    .window_i    (window_q),
    .wr_o        (wr),
    .wr_idx_o    (wr_idx),
    .done_o      (done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // a query only leaves the row while an item is in flight
  a_tail_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_pkt[ENTRIES].valid |-> busy_q)
    else $error("scan packet left the row with no item in flight");

  a_walk_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##(ENTRIES+1) chain_pkt[ENTRIES].valid)
    else $error("scan packet did not reach the end of the row in time");

  a_one_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.suppress && out_data_o.new_entry))
    else $error("result both suppressed and new");

  a_wr_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> busy_q && !in_ready_o)
    else $error("table write outside an item");

endmodule

`default_nettype wire

### test/mdtw_checker.sv
// mdtw_checker: watches the input, result and window-write channels of the dedup table
// keeps its own address/time table, predicts suppress/new_entry per input transfer, compares
// depends on mdtw_pkg
`timescale 1ns / 100ps

module mdtw_checker #(
  parameter int unsigned ENTRIES = mdtw_pkg::DefEntries
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  mdtw_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  mdtw_pkg::out_t out_data_i,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic [31:0]    cfg_data_i,
  output int             results_seen_o,
  output int             errors_o
);

  logic [mdtw_pkg::AddrW-1:0] seen_addr [ENTRIES];
  logic [mdtw_pkg::TimeW-1:0] seen_time [ENTRIES];
  logic [mdtw_pkg::TimeW-1:0] window_q;
  mdtw_pkg::out_t             verdict_q [$];
  int                         errors;

  assign errors_o = errors;

  // first matching entry decides; on a miss the smallest stored time is evicted
  task automatic classify_station(input mdtw_pkg::in_t item, output mdtw_pkg::out_t verdict);
    int                         hit;
    int                         oldest;
    logic [mdtw_pkg::TimeW-1:0] age;
    hit     = -1;
    oldest  = 0;
    verdict = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && seen_addr[i] == item.station_addr) hit = i;
    end
    if (hit >= 0) begin
      age = item.time_ms - seen_time[hit];
      if (age < window_q) begin
        verdict.suppress = 1'b1;
      end else begin
        seen_time[hit] = item.time_ms;
      end
    end else begin
      // plain unsigned compare, wrap ignored here
      for (int i = 1; i < ENTRIES; i++) begin
        if (seen_time[i] < seen_time[oldest]) oldest = i;
      end
      seen_addr[oldest] = item.station_addr;
      seen_time[oldest] = item.time_ms;
      verdict.new_entry = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mdtw_pkg::out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        seen_addr[i] = '0;
        seen_time[i] = '0;
      end
      window_q = mdtw_pkg::WindowReset;
      verdict_q.delete();
      errors = 0;
      results_seen_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) window_q = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        results_seen_o <= results_seen_o + 1;
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result transfer: suppress=%0b new_entry=%0b",
                     out_data_i.suppress, out_data_i.new_entry);
          end
        end else begin
          want = verdict_q.pop_front();
          if (out_data_i.suppress !== want.suppress ||
              out_data_i.new_entry !== want.new_entry) begin
            errors++;
            if (errors <= 10) begin
              $display("result %0d: expected suppress=%0b new_entry=%0b, got suppress=%0b new_entry=%0b",
                       results_seen_o, want.suppress, want.new_entry,
                       out_data_i.suppress, out_data_i.new_entry);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        classify_station(in_data_i, want);
        verdict_q.push_back(want);
      end
    end
  end

endmodule

### test/tb.sv
// tb: stimulus and verdict for mac_dedup_time_window
// drives input, result and window-write channels with random gaps; checking in mdtw_checker
// depends on mdtw_pkg, mac_dedup_time_window, mdtw_checker
`timescale 1ns / 100ps

module tb;

  localparam int unsigned ENTRIES = mdtw_pkg::DefEntries;
  localparam int          POOL    = 40;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  mdtw_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_ready_i;
  mdtw_pkg::out_t out_data_o;
  logic           cfg_valid_i;
  logic           cfg_ready_o;
  logic [31:0]    cfg_data_i;

  int items_sent;
  int results_seen;
  int errors;
  bit held_long;

  mac_dedup_time_window #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  mdtw_checker #(
    .ENTRIES(ENTRIES)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_i    (out_data_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .results_seen_o(results_seen),
    .errors_o      (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [47:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  task automatic send_item(input logic [47:0] addr, input logic [31:0] stamp, input int gap);
    mdtw_pkg::in_t item;
    item.station_addr = addr;
    item.time_ms      = stamp;
    in_data_i  <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // window changes only once every result is back
  task automatic write_window(input logic [31:0] w);
    in_valid_i <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
    cfg_data_i  <= w;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [31:0] w, input int n, input bit near_wrap);
    logic [47:0] pool [POOL];
    logic [31:0] clock_ms;
    logic [31:0] step_max;
    logic [47:0] addr;
    logic [31:0] stamp;
    int          burst_left;
    int          r;
    write_window(w);
    for (int i = 0; i < POOL; i++) pool[i] = rand_addr();
    pool[0] = '0;
    pool[1] = '1;
    if (w == 0) step_max = 200;
    else if (w > 32'h0100_0000) step_max = 5000;
    else step_max = w / 10 + 1;
    clock_ms   = near_wrap ? 32'hFFFF_FFFF - $urandom_range(0, 200000) : $urandom;
    burst_left = 0;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        // repeated stations on an advancing clock, hot subset hit more often
        addr = ($urandom_range(0, 99) < 60) ? pool[$urandom_range(0, 11)]
                                            : pool[$urandom_range(0, POOL - 1)];
        if ($urandom_range(0, 19) == 0) clock_ms += $urandom;
        else clock_ms += $urandom_range(0, step_max);
        stamp = clock_ms;
      end else begin
        addr  = rand_addr();
        stamp = $urandom;
      end
      if (burst_left == 0 && $urandom_range(0, 99) == 0) burst_left = 50;
      if (burst_left > 0) burst_left--;
      send_item(addr, stamp, (burst_left > 0) ? 0 : pick_gap());
    end
  endtask

  // result side: random stalls plus one long hold-off while items keep coming
  initial begin
    int on_len;
    int off_len;
    held_long = 1'b0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      repeat (on_len) @(posedge clk_i);
      if (!held_long && results_seen >= 400) begin
        held_long = 1'b1;
        out_ready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
      end else begin
        off_len = pick_gap();
        if (off_len > 0) begin
          out_ready_i <= 1'b0;
          repeat (off_len) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    items_sent = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // cleared table holds address 0 at time 0
    send_item(48'h0, 32'd0, 1);
    send_item(48'h0, 32'd5000, 0);
    send_item(48'h0, 32'd9999, 2);
    send_item(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
    // age across the timestamp wrap
    send_item(48'hFFFF_FFFF_FFFF, 32'h0000_0100, 1);
    send_item(48'hAAAA_AAAA_AAAA, 32'h0000_0200, 0);
    send_item(48'h5555_5555_5555, 32'h0000_0300, 0);
    send_item(48'hAAAA_AAAA_AAAA, 32'd5511, 1);
    send_item(48'hAAAA_AAAA_AAAA, 32'd5512, 0);

    // zero window never suppresses
    write_window(32'd0);
    send_item(48'h5555_5555_5555, 32'h0000_0300, 0);
    send_item(48'h5555_5555_5555, 32'h0000_0300, 1);

    write_window(32'hFFFF_FFFF);
    send_item(48'h5555_5555_5555, 32'h0000_02FF, 0);
    send_item(48'h5555_5555_5555, 32'h0000_02FF, 1);

    write_window(32'd1);
    send_item(48'h5555_5555_5555, 32'h0000_02FF, 0);
    send_item(48'h5555_5555_5555, 32'h0000_0300, 0);
    for (int i = 0; i < 7; i++) send_item(rand_addr(), 32'h1000 + i, i % 2);

    run_phase(mdtw_pkg::WindowReset, 210, 1'b0);
    run_phase(32'd0, 150, 1'b0);
    run_phase(32'hFFFF_FFFF, 150, 1'b0);
    run_phase(32'd1, 150, 1'b1);
    run_phase($urandom_range(200, 40000), 300, 1'b1);
    run_phase($urandom, 150, 1'b0);
    run_phase(mdtw_pkg::WindowReset, 150, 1'b0);

    in_valid_i <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
    repeat (ENTRIES + 20) @(posedge clk_i);
    if (errors == 0 && results_seen == items_sent) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### mac_dedup_time_window.f
rtl/mdtw_pkg.sv
rtl/mdtw_cell.sv
rtl/mdtw_out.sv
rtl/mac_dedup_time_window.sv
test/mdtw_checker.sv
test/tb.sv
